FILE: hdl/bfki_pkg.sv
// Shared types, constants and hash helpers for the Bloom k-mer insert unit.
`default_nettype none
package bfki_pkg;

   localparam int MaxKmer = 32;
   localparam int MaxHashes = 16;
   localparam int StoreBytes = 131072;
   localparam int KmerIdxW = $clog2(MaxKmer);
   localparam int HashIdxW = $clog2(MaxHashes);
   localparam int AddrW = $clog2(StoreBytes);
   localparam int BitIdxW = AddrW + 3;
   localparam int CsrDataW = 21;
   localparam logic [21:0] FullWidth = 22'(StoreBytes * 8);

   localparam logic [1:0] CMD_CHAR = 2'd0;
   localparam logic [1:0] CMD_SEED = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] CSR_VECTOR_BITS = 2'd0;
   localparam logic [1:0] CSR_HASH_COUNT = 2'd1;
   localparam logic [1:0] CSR_KMER_SIZE = 2'd2;
   localparam logic [1:0] CSR_THRESHOLD = 2'd3;

   localparam logic [31:0] C1 = 32'hcc9e2d51;
   localparam logic [31:0] C2 = 32'h1b873593;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] kmer_char;
      logic [15:0] occurrence_count;
      logic [3:0] seed_slot;
      logic [31:0] seed_word;
      logic [16:0] byte_address;
   } req_type;

   typedef struct packed {
      logic result_kind;
      logic [19:0] set_index;
      logic [7:0] read_byte;
      logic last_of_run;
   } rsp_type;

   // Work handed from the front end to the hash/store back end.
   typedef struct packed {
      logic is_read;
      logic [AddrW-1:0] addr;
      logic addr_ok;
      logic [5:0] klen;
      logic [4:0] hc;
      logic [21:0] width;
   } job_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
      rotl = (x << r) | (x >> (32 - r));
   endfunction

endpackage
`default_nettype wire

FILE: hdl/bfki_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bfki_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] addr,
   input wire logic [Width-1:0] wr_data,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: hdl/bfki_front.sv
// Front end: collects k-mer characters, loads seeds, classifies commands into jobs.
`default_nettype none
module bfki_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic accept,
   input wire bfki_pkg::req_type req,
   input wire logic [20:0] vector_bits,
   input wire logic [4:0] hash_count,
   input wire logic [5:0] kmer_size,
   input wire logic [15:0] threshold,
   output logic job_valid,
   output bfki_pkg::job_type job,
   output logic [7:0] kbuf [bfki_pkg::MaxKmer],
   output logic [31:0] seeds [bfki_pkg::MaxHashes]
);
   logic [5:0] char_count_ff, char_count_in;
   logic [5:0] klen;
   logic [4:0] hc;
   logic [21:0] width;
   logic done;

   // Clamp configuration to legal ranges.
   always_comb begin
      klen = (kmer_size == 6'd0) ? 6'd1 :
             (kmer_size > 6'(bfki_pkg::MaxKmer)) ? 6'(bfki_pkg::MaxKmer) : kmer_size;
      hc = (hash_count == 5'd0) ? 5'd1 :
           (hash_count > 5'(bfki_pkg::MaxHashes)) ? 5'(bfki_pkg::MaxHashes) : hash_count;
      width = (vector_bits == 21'd0 || {1'b0, vector_bits} > bfki_pkg::FullWidth) ?
              bfki_pkg::FullWidth : {1'b0, vector_bits};
      done = (7'(char_count_ff) + 7'd1) >= {1'b0, klen};
      char_count_in = char_count_ff;
      if (accept && req.command == bfki_pkg::CMD_CHAR) begin
         char_count_in = done ? 6'd0 : char_count_ff + 6'd1;
      end
   end

   // Character buffer and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
      end else begin
         char_count_ff <= char_count_in;
      end
      if (accept && req.command == bfki_pkg::CMD_CHAR &&
          char_count_ff < 6'(bfki_pkg::MaxKmer)) begin
         kbuf[char_count_ff[bfki_pkg::KmerIdxW-1:0]] <= req.kmer_char;
      end
   end

   // Seed table, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bfki_pkg::MaxHashes; i++) begin
            seeds[i] <= '0;
         end
      end else if (accept && req.command == bfki_pkg::CMD_SEED) begin
         seeds[req.seed_slot[bfki_pkg::HashIdxW-1:0]] <= req.seed_word;
      end
   end

   // Job issue to the back end.
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid <= 1'b0;
      end else begin
         job_valid <= accept && ((req.command == bfki_pkg::CMD_READ) ||
                      (req.command == bfki_pkg::CMD_CHAR && done &&
                       req.occurrence_count >= threshold));
      end
      job.is_read <= (req.command == bfki_pkg::CMD_READ);
      job.addr <= req.byte_address[bfki_pkg::AddrW-1:0];
      job.addr_ok <= 32'(req.byte_address) < bfki_pkg::StoreBytes;
      job.klen <= klen;
      job.hc <= hc;
      job.width <= width;
   end
endmodule
`default_nettype wire

FILE: hdl/bfki_back.sv
// Back end: store clearing, Murmur hashing, modulo reduction, vector update and reads.
`default_nettype none
module bfki_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic job_valid,
   input wire bfki_pkg::job_type job,
   input wire logic [7:0] kbuf [bfki_pkg::MaxKmer],
   input wire logic [31:0] seeds [bfki_pkg::MaxHashes],
   output logic busy,
   output logic rsp_strobe,
   output bfki_pkg::rsp_type rsp
);
   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001, S_IDLE = 10'b0000000010,
      S_BLOCK = 10'b0000000100, S_MIX1 = 10'b0000001000,
      S_MIX2 = 10'b0000010000, S_FIN1 = 10'b0000100000,
      S_FIN2 = 10'b0001000000, S_MOD = 10'b0010000000,
      S_RMW = 10'b0100000000, S_RD = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   bfki_pkg::job_type job_ff;
   logic [31:0] h_ff, k_ff;
   logic [3:0] blk_ff;
   logic [4:0] hsel_ff;
   logic [5:0] mix_ff;
   logic [21:0] rem_ff;
   logic [bfki_pkg::AddrW-1:0] clr_ff;
   logic rd_wait_ff;

   logic ram_we;
   logic [bfki_pkg::AddrW-1:0] ram_addr;
   logic [7:0] ram_wd, ram_rd;
   logic [5:0] nblk, tail, base;
   logic [31:0] kword;
   logic [21:0] rem_shift;

   bfki_ram #(.Width(8), .Depth(bfki_pkg::StoreBytes)) u_store (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wd), .rd_data(ram_rd)
   );

   // Gather the current block's bytes, zeroing past the k-mer end.
   always_comb begin
      nblk = {2'b00, job_ff.klen[5:2]};
      tail = {4'b0, job_ff.klen[1:0]};
      base = {blk_ff, 2'b00};
      kword = '0;
      for (int b = 0; b < 4; b++) begin
         if ((7'(base) + 7'(b)) < {1'b0, job_ff.klen}) begin
            kword[8*b +: 8] = kbuf[5'(base + 6'(b))];
         end
      end
      rem_shift = {rem_ff[20:0], h_ff[31]};
   end

   assign busy = (state_ff != S_IDLE) || job_valid;

   // Store port control.
   always_comb begin
      ram_we = 1'b0;
      ram_wd = '0;
      ram_addr = rem_ff[bfki_pkg::BitIdxW-1:3];
      if (state_ff == S_CLEAR) begin
         ram_we = 1'b1;
         ram_addr = clr_ff;
      end else if (state_ff == S_RD) begin
         ram_addr = job_ff.addr;
      end else if (state_ff == S_RMW && rd_wait_ff) begin
         ram_we = 1'b1;
         ram_wd = ram_rd | (8'd1 << rem_ff[2:0]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == '1) state_in = S_IDLE;
         S_IDLE: if (job_valid) state_in = job.is_read ? S_RD : S_BLOCK;
         S_BLOCK: state_in = S_MIX1;
         S_MIX1: state_in = S_MIX2;
         S_MIX2: if (4'(blk_ff) >= 4'(nblk)) state_in = S_FIN1;
                 else state_in = S_BLOCK;
         S_FIN1: state_in = S_FIN2;
         S_FIN2: if (mix_ff == 6'd5) state_in = S_MOD;
         S_MOD: if (mix_ff == 6'd0) state_in = S_RMW;
         S_RMW: if (rd_wait_ff) state_in = ((hsel_ff + 5'd1) == job_ff.hc) ? S_IDLE : S_BLOCK;
         S_RD: if (rd_wait_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath: hash steps, modulo reduction, vector update and read responses.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rd_wait_ff <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_strobe <= 1'b0;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         rd_wait_ff <= ((state_ff == S_RMW) || (state_ff == S_RD)) && !rd_wait_ff;
         if ((state_ff == S_RMW || state_ff == S_RD) && rd_wait_ff) rsp_strobe <= 1'b1;
      end
      unique case (state_ff)
         S_IDLE: begin
            job_ff <= job;
            hsel_ff <= '0;
            blk_ff <= '0;
            h_ff <= seeds[0];
            mix_ff <= '0;
         end
         S_BLOCK: k_ff <= kword * bfki_pkg::C1;
         S_MIX1: k_ff <= bfki_pkg::rotl(k_ff, 15) * bfki_pkg::C2;
         S_MIX2: begin
            if (4'(blk_ff) < 4'(nblk)) begin
               h_ff <= bfki_pkg::rotl(h_ff ^ k_ff, 13) * 32'd5 + 32'he6546b64;
               blk_ff <= blk_ff + 4'd1;
            end else begin
               h_ff <= ((tail != 6'd0) ? (h_ff ^ k_ff) : h_ff) ^ {26'b0, job_ff.klen};
               mix_ff <= '0;
            end
         end
         S_FIN1: h_ff <= h_ff ^ (h_ff >> 16);
         S_FIN2: begin
            unique case (mix_ff)
               6'd0: begin h_ff <= h_ff * 32'h85ebca6b; mix_ff <= 6'd1; end
               6'd1: begin h_ff <= h_ff ^ (h_ff >> 13); mix_ff <= 6'd2; end
               6'd2: begin h_ff <= h_ff * 32'hc2b2ae35; mix_ff <= 6'd3; end
               6'd3: begin h_ff <= h_ff ^ (h_ff >> 16); mix_ff <= 6'd4; end
               6'd4: begin rem_ff <= '0; mix_ff <= 6'd5; end
               default: begin
                  mix_ff <= 6'd31;
               end
            endcase
         end
         S_MOD: begin
            // Restoring remainder: one hash bit per cycle, most significant first.
            h_ff <= {h_ff[30:0], 1'b0};
            rem_ff <= (rem_shift >= job_ff.width) ? rem_shift - job_ff.width : rem_shift;
            if (mix_ff != 6'd0) mix_ff <= mix_ff - 6'd1;
         end
         S_RMW: if (rd_wait_ff) begin
            rsp.result_kind <= 1'b0;
            rsp.set_index <= rem_ff[19:0];
            rsp.read_byte <= '0;
            rsp.last_of_run <= (hsel_ff + 5'd1) == job_ff.hc;
            hsel_ff <= hsel_ff + 5'd1;
            blk_ff <= '0;
            h_ff <= seeds[hsel_ff[3:0] + 4'd1];
         end
         S_RD: if (rd_wait_ff) begin
            rsp.result_kind <= 1'b1;
            rsp.set_index <= '0;
            rsp.read_byte <= job_ff.addr_ok ? ram_rd : 8'd0;
            rsp.last_of_run <= 1'b1;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

FILE: hdl/bloom_filter_kmer_insert_unit.sv
// Top level of the Bloom filter k-mer insert unit.
// A character or seed word is accepted every cycle while busy is low; a read
// strobes its result as busy drops, so the next request waits for that result.
// A qualifying k-mer of L characters is handed off to the back end, then per hash
// runs L/4+1 block rounds, finalization, bit-serial modulo and a store update.
// After reset the whole store is cleared while busy is high.
// Results appear as one-cycle strobes; the receiver cannot stall.
`default_nettype none
module bloom_filter_kmer_insert_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire bfki_pkg::req_type req_word,
   output logic rsp_strobe,
   output bfki_pkg::rsp_type rsp_word,
   input wire logic csr_write,
   input wire logic [1:0] csr_index,
   input wire logic [20:0] csr_data
);
   logic [20:0] vector_bits_ff;
   logic [4:0] hash_count_ff;
   logic [5:0] kmer_size_ff;
   logic [15:0] threshold_ff;
   logic accept, job_valid, back_busy;
   bfki_pkg::job_type job;
   logic [7:0] kbuf [bfki_pkg::MaxKmer];
   logic [31:0] seeds [bfki_pkg::MaxHashes];

   assign busy = back_busy;
   assign accept = start && !busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vector_bits_ff <= 21'd1048576;
         hash_count_ff <= 5'd4;
         kmer_size_ff <= 6'd31;
         threshold_ff <= 16'd2;
      end else if (csr_write) begin
         unique case (csr_index)
            bfki_pkg::CSR_VECTOR_BITS: vector_bits_ff <= csr_data;
            bfki_pkg::CSR_HASH_COUNT: hash_count_ff <= csr_data[4:0];
            bfki_pkg::CSR_KMER_SIZE: kmer_size_ff <= csr_data[5:0];
            bfki_pkg::CSR_THRESHOLD: threshold_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   bfki_front u_front (
      .clock(clock), .reset(reset), .accept(accept), .req(req_word),
      .vector_bits(vector_bits_ff), .hash_count(hash_count_ff),
      .kmer_size(kmer_size_ff), .threshold(threshold_ff),
      .job_valid(job_valid), .job(job), .kbuf(kbuf), .seeds(seeds)
   );

   bfki_back u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job(job),
      .kbuf(kbuf), .seeds(seeds), .busy(back_busy),
      .rsp_strobe(rsp_strobe), .rsp(rsp_word)
   );
endmodule
`default_nettype wire
